FILE: sv/laet_pkg.sv
// shared types and constants of the load average tracker
package laet_pkg;

    localparam int TICK_W     = 64;
    localparam int CPU_W      = 7;
    localparam int TAU_W      = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;
    localparam int TAUCPU_W   = TAU_W + CPU_W;

    localparam logic [CFG_IDX_W-1:0] CFG_NUM_CPUS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TAU_SHORT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TAU_MID   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TAU_LONG  = 2'd3;

    localparam logic [CPU_W-1:0] CPU_MAX = 7'd64;

    localparam logic [1:0] AVG_SHORT = 2'd0;
    localparam logic [1:0] AVG_MID   = 2'd1;
    localparam logic [1:0] AVG_LONG  = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_BUSY,
        S_DBUSY,
        S_IMUL,
        S_IDIV_LD,
        S_DIV,
        S_DSAVE,
        S_KMUL1,
        S_KMUL2,
        S_PREP,
        S_NMUL,
        S_EDIV_LD,
        S_DONE
    } state_t;

endpackage

FILE: sv/load_average_ema_tracker.sv
// load average tracker: three moving averages of cpu load from tick counters
// a new input word is taken only in idle, once the previous result has gone to the output register;
// a first sample or a total that did not grow skips the averaging and keeps the averages
// each averaged word makes four passes through the shared restoring divider (W steps each),
// W = FRACTION_BITS+7, and uses the shared 32-bit x MB multiplier
// reset: averages and previous sample cleared, registers to 1, 60, 300 and 900
module load_average_ema_tracker #(
    parameter int unsigned TICKS_PER_SECOND = 10000000,
    parameter int unsigned FRACTION_BITS    = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [laet_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [laet_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [laet_pkg::TICK_W-1:0]         idle_ticks,
    input  logic [laet_pkg::TICK_W-1:0]         kernel_ticks,
    input  logic [laet_pkg::TICK_W-1:0]         user_ticks,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [FRACTION_BITS+6:0]            load_short,
    output logic [FRACTION_BITS+6:0]            load_mid,
    output logic [FRACTION_BITS+6:0]            load_long
);

    localparam int W   = FRACTION_BITS + 7;
    localparam int MB  = (W > laet_pkg::TAUCPU_W) ? W : laet_pkg::TAUCPU_W;
    localparam int AW  = 64 + MB;
    localparam int PW  = 32 + MB;
    localparam int NW  = 64 + W;
    localparam int CW  = $clog2(W);
    localparam int IPW = 64 + laet_pkg::CPU_W;
    localparam logic [W-1:0] CAP = {1'b1, {(W-1){1'b0}}};

    laet_pkg::state_t state_reg, state_next;

    logic [laet_pkg::CPU_W-1:0] num_cpus_reg;
    logic [laet_pkg::TAU_W-1:0] tau_short_reg, tau_mid_reg, tau_long_reg;

    logic [63:0]   idle_reg, total_reg, busy_reg, dtot_reg;
    logic [63:0]   prev_busy_reg, prev_total_reg;
    logic          upd_reg;
    logic [63:0]   mx_reg;
    logic [MB-1:0] mb_reg;
    logic          phase_reg;
    logic [AW-1:0] acc_reg;
    logic [64:0]   den_reg, rem_reg;
    logic [W-1:0]  nlo_reg, q_reg;
    logic [CW-1:0] cnt_reg;
    logic          ovf_reg, ema_reg, dir_reg;
    logic [1:0]    sel_reg;
    logic [W-1:0]  inst_reg;
    logic [W-1:0]  avg_reg [3];
    logic          out_valid_reg;
    logic [W-1:0]  out_short_reg, out_mid_reg, out_long_reg;

    logic [laet_pkg::CPU_W-1:0] cpus_eff;
    logic [31:0]   mul_a;
    logic [PW-1:0] prod;
    logic [AW-1:0] acc_next;
    logic [65:0]   trial, diff;
    logic          ge;
    logic [NW-1:0] inum, enum_w;
    logic [63:0]   busy_new, dbusy;
    logic [W-1:0]  avg_cur, mag, ema_new, inst_sat;
    logic [1:0]    sel_next;
    logic [laet_pkg::TAU_W-1:0] tau_sel, tau_eff;
    logic          mul_state, can_load;

    assign cfg_ready  = 1'b1;
    assign in_ready   = (state_reg == laet_pkg::S_IDLE);
    assign out_valid  = out_valid_reg;
    assign load_short = out_short_reg;
    assign load_mid   = out_mid_reg;
    assign load_long  = out_long_reg;

    assign cpus_eff = (num_cpus_reg == '0) ? laet_pkg::CPU_W'(1) :
                      ((num_cpus_reg > laet_pkg::CPU_MAX) ? laet_pkg::CPU_MAX : num_cpus_reg);

    // shared multiplier: 64-bit operand taken in two 32-bit halves
    assign mul_a    = phase_reg ? mx_reg[63:32] : mx_reg[31:0];
    assign prod     = {{MB{1'b0}}, mul_a} * {32'd0, mb_reg};
    assign acc_next = phase_reg ? (acc_reg + {prod, 32'd0}) : {32'd0, prod};

    // shared restoring divider step
    assign trial = {rem_reg, nlo_reg[W-1]};
    assign ge    = (trial >= {1'b0, den_reg});
    assign diff  = trial - {1'b0, den_reg};

    assign inum   = {acc_reg[IPW-1:0], {FRACTION_BITS{1'b0}}};
    assign enum_w = acc_reg[NW-1:0];

    assign busy_new = (total_reg > idle_reg) ? (total_reg - idle_reg) : 64'd0;
    assign dbusy    = (busy_reg >= prev_busy_reg) ? (busy_reg - prev_busy_reg) : 64'd0;

    assign avg_cur  = avg_reg[sel_reg];
    assign mag      = (inst_reg >= avg_cur) ? (inst_reg - avg_cur) : (avg_cur - inst_reg);
    assign ema_new  = dir_reg ? (avg_cur + q_reg) : (avg_cur - q_reg);
    assign inst_sat = (ovf_reg || (q_reg > CAP)) ? CAP : q_reg;

    assign sel_next = ema_reg ? (sel_reg + 2'd1) : laet_pkg::AVG_SHORT;

    always_comb
    begin
        case (sel_next)
            laet_pkg::AVG_SHORT: tau_sel = tau_short_reg;
            laet_pkg::AVG_MID:   tau_sel = tau_mid_reg;
            default:             tau_sel = tau_long_reg;
        endcase
    end

    assign tau_eff = (tau_sel == '0) ? laet_pkg::TAU_W'(1) : tau_sel;

    assign mul_state = (state_reg == laet_pkg::S_IMUL)  || (state_reg == laet_pkg::S_KMUL1) ||
                       (state_reg == laet_pkg::S_KMUL2) || (state_reg == laet_pkg::S_NMUL);
    assign can_load  = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= laet_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            laet_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = laet_pkg::S_BUSY;
                end
            end
            laet_pkg::S_BUSY:    state_next = laet_pkg::S_DBUSY;
            laet_pkg::S_DBUSY:   state_next = upd_reg ? laet_pkg::S_IMUL : laet_pkg::S_DONE;
            laet_pkg::S_IMUL:    state_next = phase_reg ? laet_pkg::S_IDIV_LD : laet_pkg::S_IMUL;
            laet_pkg::S_IDIV_LD: state_next = laet_pkg::S_DIV;
            laet_pkg::S_DIV:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = laet_pkg::S_DSAVE;
                end
            end
            laet_pkg::S_DSAVE:
            begin
                if (ema_reg && (sel_reg == laet_pkg::AVG_LONG))
                begin
                    state_next = laet_pkg::S_DONE;
                end
                else
                begin
                    state_next = laet_pkg::S_KMUL1;
                end
            end
            laet_pkg::S_KMUL1:   state_next = phase_reg ? laet_pkg::S_KMUL2 : laet_pkg::S_KMUL1;
            laet_pkg::S_KMUL2:   state_next = phase_reg ? laet_pkg::S_PREP : laet_pkg::S_KMUL2;
            laet_pkg::S_PREP:    state_next = laet_pkg::S_NMUL;
            laet_pkg::S_NMUL:    state_next = phase_reg ? laet_pkg::S_EDIV_LD : laet_pkg::S_NMUL;
            laet_pkg::S_EDIV_LD: state_next = laet_pkg::S_DIV;
            laet_pkg::S_DONE:
            begin
                if (can_load)
                begin
                    state_next = laet_pkg::S_IDLE;
                end
            end
            default:             state_next = laet_pkg::S_IDLE;
        endcase
    end

    // control, configuration and tracker state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_cpus_reg   <= laet_pkg::CPU_W'(1);
            tau_short_reg  <= laet_pkg::TAU_W'(60);
            tau_mid_reg    <= laet_pkg::TAU_W'(300);
            tau_long_reg   <= laet_pkg::TAU_W'(900);
            prev_busy_reg  <= '0;
            prev_total_reg <= '0;
            upd_reg        <= 1'b0;
            phase_reg      <= 1'b0;
            cnt_reg        <= '0;
            ema_reg        <= 1'b0;
            sel_reg        <= laet_pkg::AVG_SHORT;
            out_valid_reg  <= 1'b0;
            avg_reg[0]     <= '0;
            avg_reg[1]     <= '0;
            avg_reg[2]     <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    laet_pkg::CFG_NUM_CPUS:  num_cpus_reg  <= cfg_data[laet_pkg::CPU_W-1:0];
                    laet_pkg::CFG_TAU_SHORT: tau_short_reg <= cfg_data[laet_pkg::TAU_W-1:0];
                    laet_pkg::CFG_TAU_MID:   tau_mid_reg   <= cfg_data[laet_pkg::TAU_W-1:0];
                    laet_pkg::CFG_TAU_LONG:  tau_long_reg  <= cfg_data[laet_pkg::TAU_W-1:0];
                    default: ;
                endcase
            end

            phase_reg <= mul_state ? ~phase_reg : 1'b0;

            case (state_reg)
                laet_pkg::S_BUSY:
                begin
                    // zero previous total means no previous sample
                    upd_reg        <= (prev_total_reg != '0) && (total_reg > prev_total_reg);
                    prev_total_reg <= total_reg;
                end
                laet_pkg::S_DBUSY:
                begin
                    prev_busy_reg <= busy_reg;
                    ema_reg       <= 1'b0;
                end
                laet_pkg::S_IDIV_LD, laet_pkg::S_EDIV_LD:
                begin
                    cnt_reg <= CW'(W - 1);
                end
                laet_pkg::S_DIV:
                begin
                    cnt_reg <= cnt_reg - CW'(1);
                end
                laet_pkg::S_DSAVE:
                begin
                    if (ema_reg)
                    begin
                        avg_reg[sel_reg] <= ema_new;
                    end
                    sel_reg <= sel_next;
                    ema_reg <= 1'b1;
                end
                default: ;
            endcase

            if ((state_reg == laet_pkg::S_DONE) && can_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            laet_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    idle_reg  <= idle_ticks;
                    total_reg <= kernel_ticks + user_ticks;
                end
            end
            laet_pkg::S_BUSY:
            begin
                busy_reg <= busy_new;
                dtot_reg <= total_reg - prev_total_reg;
            end
            laet_pkg::S_DBUSY:
            begin
                den_reg <= {1'b0, dtot_reg};
                mx_reg  <= dbusy;
                mb_reg  <= MB'(cpus_eff);
            end
            laet_pkg::S_IMUL, laet_pkg::S_NMUL:
            begin
                acc_reg <= acc_next;
            end
            laet_pkg::S_IDIV_LD:
            begin
                rem_reg <= {1'b0, inum[NW-1:W]};
                nlo_reg <= inum[W-1:0];
                ovf_reg <= ({1'b0, inum[NW-1:W]} >= den_reg);
            end
            laet_pkg::S_EDIV_LD:
            begin
                // step is below the magnitude, so the high part never overflows
                rem_reg <= {1'b0, enum_w[NW-1:W]};
                nlo_reg <= enum_w[W-1:0];
                ovf_reg <= 1'b0;
            end
            laet_pkg::S_DIV:
            begin
                rem_reg <= ge ? diff[64:0] : trial[64:0];
                nlo_reg <= {nlo_reg[W-2:0], 1'b0};
                q_reg   <= {q_reg[W-2:0], ge};
            end
            laet_pkg::S_DSAVE:
            begin
                if (!ema_reg)
                begin
                    inst_reg <= inst_sat;
                end
                mx_reg <= 64'(tau_eff);
                mb_reg <= MB'(cpus_eff);
            end
            laet_pkg::S_KMUL1:
            begin
                acc_reg <= acc_next;
                if (phase_reg)
                begin
                    // tau * cpus, then times ticks per second
                    mx_reg <= 64'(TICKS_PER_SECOND);
                    mb_reg <= acc_next[MB-1:0];
                end
            end
            laet_pkg::S_KMUL2:
            begin
                acc_reg <= acc_next;
            end
            laet_pkg::S_PREP:
            begin
                den_reg <= {1'b0, dtot_reg} + {1'b0, acc_reg[63:0]};
                mx_reg  <= dtot_reg;
                mb_reg  <= MB'(mag);
                dir_reg <= (inst_reg >= avg_cur);
            end
            laet_pkg::S_DONE:
            begin
                if (can_load)
                begin
                    out_short_reg <= avg_reg[0];
                    out_mid_reg   <= avg_reg[1];
                    out_long_reg  <= avg_reg[2];
                end
            end
            default: ;
        endcase
    end

endmodule

FILE: tb/sv/laet_checker.sv
// load average checker: predicts the three moving averages and compares each output word
`timescale 1ns / 1ps
module laet_checker #(
    parameter int unsigned TICKS_PER_SECOND = 10000000,
    parameter int unsigned FRACTION_BITS    = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [laet_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [laet_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            in_valid,
    input  logic                            in_ready,
    input  logic [laet_pkg::TICK_W-1:0]     idle_ticks,
    input  logic [laet_pkg::TICK_W-1:0]     kernel_ticks,
    input  logic [laet_pkg::TICK_W-1:0]     user_ticks,
    input  logic                            out_valid,
    input  logic                            out_ready,
    input  logic [FRACTION_BITS+6:0]        load_short,
    input  logic [FRACTION_BITS+6:0]        load_mid,
    input  logic [FRACTION_BITS+6:0]        load_long,
    output int                              errors,
    output int                              pending,
    output int                              checked
);

    localparam int LOAD_W = FRACTION_BITS + 7;
    localparam logic [127:0] LOAD_CEIL = 128'(64) << FRACTION_BITS;

    typedef logic [LOAD_W-1:0] load_t;
    typedef logic [laet_pkg::TICK_W-1:0] tick_t;
    typedef struct packed {
        load_t short_load;
        load_t mid_load;
        load_t long_load;
    } load_set_t;

    logic [laet_pkg::CPU_W-1:0] cpu_reg;
    logic [laet_pkg::TAU_W-1:0] tau_short_reg;
    logic [laet_pkg::TAU_W-1:0] tau_mid_reg;
    logic [laet_pkg::TAU_W-1:0] tau_long_reg;
    tick_t            prev_busy_ticks;
    tick_t            prev_total_ticks;
    load_set_t        avg;
    load_set_t        want;
    load_set_t        expected_loads[$];
    int               err_count;
    int               check_count;

    // one average moves toward the instantaneous load, truncated toward its old value
    function automatic load_t move_toward(load_t avg_now, load_t target, tick_t span,
                                          logic [laet_pkg::TAU_W-1:0] tau,
                                          logic [127:0] cpus);
        logic [127:0] gap;
        logic [127:0] tau_sec;
        logic [127:0] num;
        logic [127:0] den;
        logic [127:0] step;
        gap     = (target >= avg_now) ? 128'(target - avg_now) : 128'(avg_now - target);
        tau_sec = (tau == '0) ? 128'd1 : 128'(tau);
        num     = 128'(span) * gap;
        den     = 128'(span) + tau_sec * cpus * 128'(TICKS_PER_SECOND);
        step    = num / den;
        return (target >= avg_now) ? avg_now + load_t'(step) : avg_now - load_t'(step);
    endfunction

    function automatic void take_sample(tick_t idle, tick_t kern, tick_t user);
        tick_t        total;
        tick_t        busy;
        tick_t        span;
        tick_t        busy_span;
        logic [127:0] cpus;
        logic [127:0] quotient;
        load_t        inst;
        total = kern + user;
        busy  = (total > idle) ? total - idle : '0;
        cpus  = (cpu_reg == '0) ? 128'd1 :
                (cpu_reg > laet_pkg::CPU_MAX) ? 128'(laet_pkg::CPU_MAX) : 128'(cpu_reg);
        // a zero stored total means no previous sample
        if (prev_total_ticks != '0 && total > prev_total_ticks)
        begin
            span      = total - prev_total_ticks;
            busy_span = (busy >= prev_busy_ticks) ? busy - prev_busy_ticks : '0;
            quotient  = (128'(busy_span) * (cpus << FRACTION_BITS)) / 128'(span);
            inst      = (quotient > LOAD_CEIL) ? load_t'(LOAD_CEIL) : load_t'(quotient);
            avg.short_load = move_toward(avg.short_load, inst, span, tau_short_reg, cpus);
            avg.mid_load   = move_toward(avg.mid_load, inst, span, tau_mid_reg, cpus);
            avg.long_load  = move_toward(avg.long_load, inst, span, tau_long_reg, cpus);
        end
        prev_busy_ticks  = busy;
        prev_total_ticks = total;
        expected_loads.push_back(avg);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cpu_reg          = 7'd1;
            tau_short_reg    = 12'd60;
            tau_mid_reg      = 12'd300;
            tau_long_reg     = 12'd900;
            prev_busy_ticks  = '0;
            prev_total_ticks = '0;
            avg              = '0;
            err_count        = 0;
            check_count      = 0;
            expected_loads.delete();
            errors  <= 0;
            pending <= 0;
            checked <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_loads.size() == 0)
                begin
                    $error("load word arrived with no sample outstanding");
                    err_count++;
                end
                else
                begin
                    want = expected_loads.pop_front();
                    if (load_short !== want.short_load)
                    begin
                        $error("load_short: expected %0d, got %0d", want.short_load, load_short);
                        err_count++;
                    end
                    if (load_mid !== want.mid_load)
                    begin
                        $error("load_mid: expected %0d, got %0d", want.mid_load, load_mid);
                        err_count++;
                    end
                    if (load_long !== want.long_load)
                    begin
                        $error("load_long: expected %0d, got %0d", want.long_load, load_long);
                        err_count++;
                    end
                    check_count++;
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    laet_pkg::CFG_NUM_CPUS:  cpu_reg       = cfg_data[laet_pkg::CPU_W-1:0];
                    laet_pkg::CFG_TAU_SHORT: tau_short_reg = cfg_data[laet_pkg::TAU_W-1:0];
                    laet_pkg::CFG_TAU_MID:   tau_mid_reg   = cfg_data[laet_pkg::TAU_W-1:0];
                    laet_pkg::CFG_TAU_LONG:  tau_long_reg  = cfg_data[laet_pkg::TAU_W-1:0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                take_sample(idle_ticks, kernel_ticks, user_ticks);
            errors  <= err_count;
            pending <= expected_loads.size();
            checked <= check_count;
        end
    end

endmodule

FILE: tb/sv/testbench.sv
// load average tracker testbench top: clock, reset, counter stimulus and verdict
`timescale 1ns / 1ps
module testbench;

    localparam int unsigned TICKS_PER_SECOND = 10000000;
    localparam int unsigned FRACTION_BITS    = 16;
    localparam int          WATCHDOG_LIMIT   = 4000;
    localparam int          SEGMENTS         = 12;
    localparam int          SEGMENT_ITEMS    = 120;
    localparam int          TAIL_CYCLES      = 150;

    typedef logic [laet_pkg::TICK_W-1:0] tick_t;

    localparam tick_t TICK_MAX  = '1;
    localparam tick_t PATTERN_A = 64'hAAAA_AAAA_AAAA_AAAA;
    localparam tick_t PATTERN_5 = 64'h5555_5555_5555_5555;

    logic                    clk          = 1'b0;
    logic                    rst_n        = 1'b0;
    logic                    cfg_valid    = 1'b0;
    logic                    cfg_ready;
    logic [laet_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [laet_pkg::CFG_DATA_W-1:0] cfg_data  = '0;
    logic                    in_valid     = 1'b0;
    logic                    in_ready;
    tick_t                   idle_ticks   = '0;
    tick_t                   kernel_ticks = '0;
    tick_t                   user_ticks   = '0;
    logic                    out_valid;
    logic                    out_ready    = 1'b0;
    logic [FRACTION_BITS+6:0] load_short;
    logic [FRACTION_BITS+6:0] load_mid;
    logic [FRACTION_BITS+6:0] load_long;

    int    errors;
    int    pending;
    int    checked;
    int    gap_pct      = 29;
    int    stall_pct    = 75;
    int    samples_sent = 0;
    int    reg_writes   = 0;
    tick_t run_idle;
    tick_t run_kern;
    tick_t run_user;

    always #2 clk = ~clk;

    load_average_ema_tracker #(
        .TICKS_PER_SECOND (TICKS_PER_SECOND),
        .FRACTION_BITS    (FRACTION_BITS)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .idle_ticks   (idle_ticks),
        .kernel_ticks (kernel_ticks),
        .user_ticks   (user_ticks),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .load_short   (load_short),
        .load_mid     (load_mid),
        .load_long    (load_long)
    );

    laet_checker #(
        .TICKS_PER_SECOND (TICKS_PER_SECOND),
        .FRACTION_BITS    (FRACTION_BITS)
    ) u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .idle_ticks   (idle_ticks),
        .kernel_ticks (kernel_ticks),
        .user_ticks   (user_ticks),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .load_short   (load_short),
        .load_mid     (load_mid),
        .load_long    (load_long),
        .errors       (errors),
        .pending      (pending),
        .checked      (checked)
    );

    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= stall_pct);

    // valid stays high across back-to-back words; this task lowers it only for a gap
    task automatic put_sample(input tick_t idle, input tick_t kern, input tick_t user);
        while ($urandom_range(99) < gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        idle_ticks   <= idle;
        kernel_ticks <= kern;
        user_ticks   <= user;
        do @(posedge clk); while (!in_ready);
        samples_sent++;
    endtask

    task automatic write_reg(input logic [laet_pkg::CFG_IDX_W-1:0] idx,
                             input logic [laet_pkg::CFG_DATA_W-1:0] word);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= word;
        do @(posedge clk); while (!cfg_ready);
        reg_writes++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    // tick span from one tick up to about 2^40
    function automatic tick_t pick_span();
        case ($urandom_range(3))
            0:       pick_span = tick_t'($urandom_range(1, 64));
            1:       pick_span = tick_t'($urandom_range(1, 5000000));
            2:       pick_span = tick_t'(TICKS_PER_SECOND) * tick_t'($urandom_range(1, 400));
            default: pick_span = {24'd0, 8'($urandom), 32'($urandom)} + 64'd1;
        endcase
    endfunction

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((cfg_valid && cfg_ready) || (in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("no word moved for %0d cycles", WATCHDOG_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin : stimulus
        tick_t                 span;
        tick_t                 busy_part;
        tick_t                 user_part;
        int                    pick;
        logic [laet_pkg::CFG_DATA_W-1:0] cpu_word;
        logic [laet_pkg::CFG_DATA_W-1:0] ts;
        logic [laet_pkg::CFG_DATA_W-1:0] tm;
        logic [laet_pkg::CFG_DATA_W-1:0] tl;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part with the registers at their reset values
        put_sample(0, 0, 0);
        put_sample(5000000, 6000000, 4000000);       // stored total was zero
        put_sample(10000000, 12000000, 8000000);     // half load over one second
        put_sample(10000000, 12000000, 8000000);     // total unchanged
        put_sample(0, 1000000, 0);                   // total fell
        put_sample(30000000, 30000000, 500000);      // busy fell
        put_sample(0, 30000000, 500001);             // idle dropped, load saturates
        put_sample(TICK_MAX, TICK_MAX, TICK_MAX);
        put_sample(0, TICK_MAX, 1);                  // kernel plus user wraps to zero
        put_sample(0, TICK_MAX, 0);
        put_sample(TICK_MAX, 1, 0);
        put_sample(1, 1, 1);                         // one tick, fully busy
        put_sample(PATTERN_A, PATTERN_5, PATTERN_5);
        put_sample(PATTERN_5, PATTERN_A, PATTERN_A);
        put_sample(0, 50000000, 0);
        put_sample(0, 100000000, 0);
        put_sample(0, 100000000, 100000000);
        put_sample(300000000, 300000000, 100000000);
        put_sample(300000000, 64'd36000000000000, 100000000);  // full load, span near 3.6e13 ticks
        wait_drained();

        run_idle = tick_t'($urandom_range(0, 1000));
        run_kern = run_idle + tick_t'($urandom_range(0, 1000));
        run_user = tick_t'($urandom_range(0, 1000));

        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            if (seg == 4)
            begin
                gap_pct   = 75;
                stall_pct = 29;
            end
            if (seg == 8)
            begin
                gap_pct   = 0;
                stall_pct = 0;
            end
            case (seg)
                0:
                begin
                    cpu_word = 12'd64;
                    ts       = 12'd1;
                    tm       = 12'd1;
                    tl       = 12'd1;
                end
                1:
                begin
                    // upper bits dropped, a zero count acts as one, zero tau as one second
                    cpu_word = 12'hF80;
                    ts       = 12'd0;
                    tm       = 12'd3600;
                    tl       = 12'hFFF;
                end
                2:
                begin
                    // 127 processors clamp to 64
                    cpu_word = 12'hFFF;
                    ts       = 12'hFFF;
                    tm       = 12'd0;
                    tl       = 12'd3600;
                end
                3:
                begin
                    cpu_word = 12'd1;
                    ts       = 12'd3600;
                    tm       = 12'd3600;
                    tl       = 12'd3600;
                end
                default:
                begin
                    cpu_word = 12'($urandom_range(1, 64));
                    ts       = 12'($urandom_range(1, 3600));
                    tm       = 12'($urandom_range(1, 3600));
                    tl       = 12'($urandom_range(1, 3600));
                end
            endcase
            write_reg(laet_pkg::CFG_NUM_CPUS, cpu_word);
            write_reg(laet_pkg::CFG_TAU_SHORT, ts);
            write_reg(laet_pkg::CFG_TAU_MID, tm);
            write_reg(laet_pkg::CFG_TAU_LONG, tl);
            cfg_valid <= 1'b0;

            for (int n = 0; n < SEGMENT_ITEMS; n++)
            begin
                pick = $urandom_range(99);
                if (pick < 72)
                begin
                    // counters advance consistently: kernel holds idle, busy is a share of span
                    span      = pick_span();
                    busy_part = (span * tick_t'($urandom_range(0, 256))) >> 8;
                    user_part = (busy_part * tick_t'($urandom_range(0, 256))) >> 8;
                    run_idle += span - busy_part;
                    run_kern += span - user_part;
                    run_user += user_part;
                end
                else if (pick < 80)
                begin
                    // resend the running counters unchanged, so their total does not grow
                end
                else if (pick < 86)
                begin
                    if ($urandom_range(1) == 1)
                        run_idle = run_idle + pick_span();
                    else
                        run_idle = run_idle - pick_span();
                    run_kern += tick_t'($urandom_range(1, 1000));
                end
                else if (pick < 93)
                begin
                    put_sample({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom});
                    continue;
                end
                else if (pick < 97)
                begin
                    // counters just below the top so kernel plus user wraps soon
                    run_kern = TICK_MAX - tick_t'($urandom_range(0, 50000000));
                    run_user = tick_t'($urandom_range(0, 50000000));
                    run_idle = run_kern - tick_t'($urandom_range(0, 1000000));
                end
                else
                begin
                    run_idle = tick_t'($urandom_range(0, 1000));
                    run_kern = run_idle + tick_t'($urandom_range(0, 1000));
                    run_user = tick_t'($urandom_range(0, 1000));
                end
                put_sample(run_idle, run_kern, run_user);
            end
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        $display("run covered %0d counter samples and %0d register writes, %0d load words checked",
                 samples_sent, reg_writes, checked);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
